@@ hw/rtl/ffms_pkg.sv @@
`timescale 1ns / 1ps

package ffms_pkg;

  localparam int MAX_SAMPLES = 64;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int SAMPLE_W    = 32;
  localparam int FRAC_W      = 16;
  localparam int VALUE_W     = 16;
  localparam int SUM_W       = 39;
  localparam int PROD_W      = 40;
  localparam int STEP_W      = 4;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT,
    OP_SCAN,
    OP_FLUSH,
    OP_CLEAR
  } op_t;

  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_IN_LAST,
    COND_SCAN_DONE,
    COND_OUT_FREE
  } cond_t;

  // one microcode word
  typedef struct packed {
    op_t   op;
    logic  clr_max;
    logic  emit;
    logic  side;
    cond_t cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic last_taken;
    logic scan_done;
    logic out_free;
    logic pend_valid;
  } status_t;

  localparam step_t ST_LOAD      = 4'd0;
  localparam step_t ST_INIT_MAX  = 4'd1;
  localparam step_t ST_SCAN_MAX  = 4'd2;
  localparam step_t ST_INIT_LOW  = 4'd3;
  localparam step_t ST_SCAN_LOW  = 4'd4;
  localparam step_t ST_INIT_HIGH = 4'd5;
  localparam step_t ST_SCAN_HIGH = 4'd6;
  localparam step_t ST_FLUSH     = 4'd7;
  localparam step_t ST_CLEAR     = 4'd8;

  function automatic ctrl_t ucode_rom(input step_t step);
    ctrl_t w;
    w = '{op: OP_NONE, clr_max: 1'b0, emit: 1'b0, side: 1'b0,
          cond: COND_ALWAYS, target: ST_LOAD};
    case (step)
      ST_LOAD: begin
        w.op = OP_LOAD; w.cond = COND_IN_LAST; w.target = ST_INIT_MAX;
      end
      ST_INIT_MAX: begin
        w.op = OP_INIT; w.clr_max = 1'b1; w.target = ST_SCAN_MAX;
      end
      ST_SCAN_MAX: begin
        w.op = OP_SCAN; w.cond = COND_SCAN_DONE; w.target = ST_INIT_LOW;
      end
      ST_INIT_LOW: begin
        w.op = OP_INIT; w.target = ST_SCAN_LOW;
      end
      ST_SCAN_LOW: begin
        w.op = OP_SCAN; w.emit = 1'b1; w.cond = COND_SCAN_DONE;
        w.target = ST_INIT_HIGH;
      end
      ST_INIT_HIGH: begin
        w.op = OP_INIT; w.target = ST_SCAN_HIGH;
      end
      ST_SCAN_HIGH: begin
        w.op = OP_SCAN; w.emit = 1'b1; w.side = 1'b1; w.cond = COND_SCAN_DONE;
        w.target = ST_FLUSH;
      end
      ST_FLUSH: begin
        w.op = OP_FLUSH; w.cond = COND_OUT_FREE; w.target = ST_CLEAR;
      end
      ST_CLEAR: begin
        w.op = OP_CLEAR; w.target = ST_LOAD;
      end
      default: begin
        w.op = OP_NONE; w.target = ST_LOAD;
      end
    endcase
    return w;
  endfunction

  // integer part, rounded toward zero
  function automatic logic [VALUE_W-1:0] trunc_int(input logic [SAMPLE_W-1:0] s);
    logic up;
    up = s[SAMPLE_W-1] && (|s[FRAC_W-1:0]);
    return s[SAMPLE_W-1:FRAC_W] + VALUE_W'(up);
  endfunction

endpackage

@@ hw/rtl/farthest_from_mean_select.sv @@
`timescale 1ns / 1ps

// Takes a set of signed Q16.16 samples, one word per cycle, the last one marked
// by s_tlast, and returns in ascending order every sample lying farthest from
// the set's mean, as its integer part rounded toward zero; m_tlast marks the
// final one and m_tuser flags a set that overran the 64-entry sample store.
// Loading runs at one word per cycle. After the last sample a microcoded
// sequencer walks the store three times (max deviation, low side, high side)
// through a single-port memory and a multiply/subtract pipeline, plus five
// control steps. s_tready stays low until the set is finished, and a walk
// that emits a result is held while the output stalls. Results leave at up
// to one per cycle.
module farthest_from_mean_select (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] sample
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] value
  output logic        m_tlast,
  output logic [0:0]  m_tuser    // [0] overflow
);

  ffms_pkg::ctrl_t   ctrl;
  ffms_pkg::status_t stat;

  ffms_sequencer u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  ffms_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .stat     (stat),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // nothing held back while new samples are taken
  a_no_pend_in_load: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !stat.pend_valid)
    else $error("selected value pending during load");

  // the last sample of a set starts evaluation
  a_eval_after_last: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> !s_tready)
    else $error("input still open after last sample");

  // a non-final result never waits while samples load
  a_mid_word_not_in_load: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> !s_tready)
    else $error("non-final result left over into load");

endmodule

@@ hw/rtl/ffms_sequencer.sv @@
`timescale 1ns / 1ps

module ffms_sequencer (
  input  logic             clk,
  input  logic             rst,
  input  ffms_pkg::status_t stat,
  output ffms_pkg::ctrl_t   ctrl
);

  ffms_pkg::step_t step;
  ffms_pkg::step_t step_next;
  logic            go;

  assign ctrl = ffms_pkg::ucode_rom(step);

  always_comb begin
    case (ctrl.cond)
      ffms_pkg::COND_ALWAYS:    go = 1'b1;
      ffms_pkg::COND_IN_LAST:   go = stat.last_taken;
      ffms_pkg::COND_SCAN_DONE: go = stat.scan_done;
      ffms_pkg::COND_OUT_FREE:  go = stat.out_free;
      default:                  go = 1'b0;
    endcase
    step_next = go ? ctrl.target : step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ffms_pkg::ST_LOAD;
    end else begin
      step <= step_next;
    end
  end

endmodule

@@ hw/rtl/ffms_datapath.sv @@
`timescale 1ns / 1ps

module ffms_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  ffms_pkg::ctrl_t               ctrl,
  output ffms_pkg::status_t             stat,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [ffms_pkg::SAMPLE_W-1:0] s_tdata,
  input  logic                          s_tlast,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [ffms_pkg::VALUE_W-1:0]  m_tdata,
  output logic                          m_tlast,
  output logic [0:0]                    m_tuser
);

  localparam int SAMPLE_W = ffms_pkg::SAMPLE_W;
  localparam int SUM_W    = ffms_pkg::SUM_W;
  localparam int PROD_W   = ffms_pkg::PROD_W;
  localparam int CNT_W    = ffms_pkg::CNT_W;
  localparam int ADDR_W   = ffms_pkg::ADDR_W;
  localparam int VALUE_W  = ffms_pkg::VALUE_W;

  logic [SAMPLE_W-1:0] mem [ffms_pkg::MAX_SAMPLES];

  logic [CNT_W-1:0]        count;
  logic signed [SUM_W-1:0] sum;
  logic                    dropped;

  logic in_take, not_full;

  // scan pipeline
  logic [CNT_W-1:0]         addr;
  logic                     v1, v2, v3;
  logic [SAMPLE_W-1:0]      rd_data, s2, s3;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] diff;
  logic [PROD_W-1:0]        dev;
  logic                     nonpos;
  logic [PROD_W-1:0]        maxdev;
  logic                     scanning, issue, match, adv;

  logic               pend_valid;
  logic [VALUE_W-1:0] pend_value;

  logic out_free, load_out, load_last;

  assign s_tready = (ctrl.op == ffms_pkg::OP_LOAD);
  assign in_take  = s_tvalid && s_tready;
  assign not_full = count < CNT_W'(ffms_pkg::MAX_SAMPLES);

  always_ff @(posedge clk) begin
    if (in_take && not_full) begin
      mem[count[ADDR_W-1:0]] <= s_tdata;
    end
    if (issue) begin
      rd_data <= mem[addr[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      sum     <= '0;
      dropped <= 1'b0;
    end else if (ctrl.op == ffms_pkg::OP_CLEAR) begin
      count   <= '0;
      sum     <= '0;
      dropped <= 1'b0;
    end else if (in_take) begin
      if (not_full) begin
        count <= count + CNT_W'(1);
        sum   <= sum + {{(SUM_W-SAMPLE_W){s_tdata[SAMPLE_W-1]}}, s_tdata};
      end else begin
        dropped <= 1'b1;
      end
    end
  end

  assign scanning = (ctrl.op == ffms_pkg::OP_SCAN);
  assign match    = v3 && scanning && ctrl.emit && (dev == maxdev) && (nonpos != ctrl.side);
  // hold the walk while a finished word cannot leave
  assign adv      = !(match && pend_valid && !out_free);
  assign issue    = scanning && adv && (addr < count);

  always_comb begin
    diff = prod - {{(PROD_W-SUM_W){sum[SUM_W-1]}}, sum};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr <= '0;
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
    end else if (ctrl.op == ffms_pkg::OP_INIT) begin
      addr <= '0;
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
    end else if (scanning && adv) begin
      if (issue) begin
        addr <= addr + CNT_W'(1);
      end
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (scanning && adv) begin
      s2     <= rd_data;
      prod   <= $signed({1'b0, count}) * $signed(rd_data);
      s3     <= s2;
      dev    <= diff[PROD_W-1] ? PROD_W'(-diff) : PROD_W'(diff);
      nonpos <= diff[PROD_W-1] || (diff == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == ffms_pkg::OP_INIT && ctrl.clr_max) begin
      maxdev <= '0;
    end else if (scanning && !ctrl.emit && v3 && (dev > maxdev)) begin
      maxdev <= dev;
    end
  end

  // one selected value is held back so the final one can carry last
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (ctrl.op == ffms_pkg::OP_CLEAR) begin
      pend_valid <= 1'b0;
    end else if (match && adv) begin
      pend_valid <= 1'b1;
    end else if (load_last) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (match && adv) begin
      pend_value <= ffms_pkg::trunc_int(s3);
    end
  end

  assign out_free  = !m_tvalid || m_tready;
  assign load_last = (ctrl.op == ffms_pkg::OP_FLUSH) && pend_valid && out_free;
  assign load_out  = (match && pend_valid && out_free) || load_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= load_out;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata    <= pend_value;
      m_tlast    <= load_last;
      m_tuser[0] <= dropped;
    end
  end

  assign stat.last_taken = in_take && s_tlast;
  assign stat.scan_done  = (addr >= count) && !v1 && !v2 && !v3;
  assign stat.out_free   = out_free;
  assign stat.pend_valid = pend_valid;

endmodule
